>>> rtl/core/sorted_breakpoint_table_macros.svh
// ----------------------------------------------------------------------------
// Sorted breakpoint table assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_BREAKPOINT_TABLE_MACROS_SVH
`define SORTED_BREAKPOINT_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define SBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_breakpoint_table: check failed");

// Invariant checked on every clock edge outside reset
`define SBT_ASSERT_ALWAYS(lbl, cond) \
    `SBT_ASSERT_IMP(lbl, 1'b1, cond)

`endif

>>> rtl/core/sbt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted breakpoint table package
// Command and status codes, and the control/flag groups of the cell row.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_REWIND = 2'd2,
        CMD_NEXT   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3,
        ST_END   = 3'd4,
        ST_PAST  = 3'd5
    } status_t;

    // broadcast to every cell
    typedef struct packed {
        logic capture;   // latch compare result against the pending address
        logic insert;    // perform the ordered insert
    } cell_ctrl_t;

    // per-cell lookup flags
    typedef struct packed {
        logic eq;        // valid entry equals the address
        logic gt_cur;    // entry under the cursor is above the address
    } cell_flag_t;

endpackage

>>> rtl/core/sorted_breakpoint_table.sv
// ----------------------------------------------------------------------------
// Sorted breakpoint table
// Ascending set of distinct breakpoint addresses with an in-order read cursor.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: cmd, tdata: address
//  m_*     | out | m_tvalid/m_tready  | tuser: status, tdata: next_address
//
//  Each item goes through accept, compare across the cell row, then execute;
//  a new item is accepted only once the last one has executed. In the compare
//  step every cell checks its entry against the address and the row's flags
//  are reduced and registered before the update. A result waiting in the
//  output register does not block the next accept; the execute step holds
//  only while that register is still full. Reset (rst_n, async low) empties
//  the set and parks the cursor; entry contents are not cleared.
//
`include "sorted_breakpoint_table_macros.svh"

module sorted_breakpoint_table
    import sbt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int ADDR_BITS   = 24,
    localparam int TDATA_W    = ((ADDR_BITS + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    // slave side
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // [ADDR_BITS-1:0] address, rest zero
    input  logic [CMD_W-1:0]    s_tuser,   // [1:0] cmd
    // master side
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [ADDR_BITS-1:0] next_address, rest zero
    output logic [STATUS_W-1:0] m_tuser    // [2:0] status
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);   // count / cursor width
    localparam int IW = $clog2(TABLE_DEPTH);       // cell index width

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    state_t               state_reg;
    cmd_t                 cmd_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        cursor_reg;
    logic                 started_reg;
    logic                 dup_reg;
    logic                 gtcur_reg;
    logic [ADDR_BITS-1:0] rd_reg;
    logic                 out_valid_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    status_t              out_status_reg;

    logic [CW-1:0]        count_next;
    logic [CW-1:0]        cursor_next;
    logic                 started_next;
    logic [ADDR_BITS-1:0] res_addr;
    status_t              res_status;
    logic                 do_insert;

    logic                 done;
    cell_ctrl_t           ctrl;
    logic [CW-1:0]        rd_full;
    logic [IW-1:0]        rd_idx;
    logic [CW-1:0]        cur_plus1;

    logic [ADDR_BITS-1:0] cell_val  [TABLE_DEPTH];
    logic                 cell_g    [TABLE_DEPTH];
    cell_flag_t           cell_flag [TABLE_DEPTH];
    logic [ADDR_BITS-1:0] cell_rd   [TABLE_DEPTH];

    logic                 any_eq;
    logic                 any_gtcur;
    logic [ADDR_BITS-1:0] rd_or;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign done     = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_addr_reg);
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Cell row: entry i lives in cell i, inserts ripple one place upward
    // ------------------------------------------------------------------
    assign cur_plus1 = cursor_reg + CW'(1);
    // first get next reads entry 0, later ones read the entry after the cursor
    assign rd_full   = started_reg ? cur_plus1 : '0;
    assign rd_idx    = rd_full[IW-1:0];

    assign ctrl.capture = (state_reg == S_CMP);
    assign ctrl.insert  = do_insert;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic [ADDR_BITS-1:0] prev_val;
            logic                 prev_g;

            if (gi == 0)
            begin : g_first
                assign prev_val = '0;
                assign prev_g   = 1'b0;
            end
            else
            begin : g_rest
                assign prev_val = cell_val[gi-1];
                assign prev_g   = cell_g[gi-1];
            end

            sbt_cell #(
                .IDX       (gi),
                .ADDR_BITS (ADDR_BITS),
                .CW        (CW),
                .IW        (IW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .addr     (addr_reg),
                .count    (count_reg),
                .rd_idx   (rd_idx),
                .cur_idx  (cursor_reg),
                .prev_val (prev_val),
                .prev_g   (prev_g),
                .val      (cell_val[gi]),
                .g        (cell_g[gi]),
                .flags    (cell_flag[gi]),
                .rd_data  (cell_rd[gi])
            );
        end
    endgenerate

    // OR-reduce the row's flags and the one-hot read
    always_comb
    begin
        any_eq    = 1'b0;
        any_gtcur = 1'b0;
        rd_or     = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            any_eq    = any_eq | cell_flag[i].eq;
            any_gtcur = any_gtcur | cell_flag[i].gt_cur;
            rd_or     = rd_or | cell_rd[i];
        end
    end

    // ------------------------------------------------------------------
    // Command execution
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        started_next = started_reg;
        res_addr     = '0;
        res_status   = ST_OK;
        do_insert    = 1'b0;

        case (cmd_reg)
            CMD_ADD:
            begin
                if (dup_reg)
                begin
                    res_status = ST_DUP;
                end
                else if (count_reg == CW'(TABLE_DEPTH))
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    do_insert  = (state_reg == S_EXEC) && done;
                    count_next = count_reg + CW'(1);
                    if (started_reg)
                    begin
                        // past end stays past end; otherwise follow the entry
                        if (cursor_reg >= count_reg)
                        begin
                            cursor_next = count_reg + CW'(1);
                        end
                        else if (gtcur_reg)
                        begin
                            cursor_next = cur_plus1;
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            CMD_REWIND:
            begin
                started_next = 1'b0;
                cursor_next  = '0;
            end
            CMD_NEXT:
            begin
                if (count_reg == '0)
                begin
                    res_status = ST_EMPTY;
                end
                else if (!started_reg)
                begin
                    started_next = 1'b1;
                    cursor_next  = '0;
                    res_addr     = rd_reg;
                end
                else if (cursor_reg >= count_reg)
                begin
                    res_status = ST_PAST;
                end
                else
                begin
                    cursor_next = cur_plus1;
                    if (cur_plus1 < count_reg)
                    begin
                        res_addr = rd_reg;
                    end
                    else
                    begin
                        res_addr   = '1;   // end sentinel
                        res_status = ST_END;
                    end
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            cursor_reg     <= '0;
            started_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            // a finishing execute step refills the register itself
            if (out_valid_reg && m_tready && state_reg != S_EXEC)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (done)
                    begin
                        count_reg      <= count_next;
                        cursor_reg     <= cursor_next;
                        started_reg    <= started_next;
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg  <= cmd_t'(s_tuser);
            addr_reg <= s_tdata[ADDR_BITS-1:0];
        end
        if (state_reg == S_CMP)
        begin
            dup_reg   <= any_eq;
            gtcur_reg <= any_gtcur;
            rd_reg    <= rd_or;
        end
        if (state_reg == S_EXEC && done)
        begin
            out_addr_reg <= res_addr;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SBT_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(TABLE_DEPTH))
    `SBT_ASSERT_IMP(a_cursor_parked, !started_reg, cursor_reg == '0)
    `SBT_ASSERT_IMP(a_sentinel, out_valid_reg && out_status_reg == ST_END, out_addr_reg == '1)
    `SBT_ASSERT_IMP(a_single_insert, do_insert, !dup_reg && count_reg < CW'(TABLE_DEPTH))

endmodule

>>> rtl/core/sbt_cell.sv
// ----------------------------------------------------------------------------
// Sorted breakpoint table cell
// Holds one entry; compares against the pending address and shifts up on insert.
// ----------------------------------------------------------------------------
module sbt_cell
    import sbt_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int ADDR_BITS = 24,
    parameter int CW        = 9,
    parameter int IW        = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [CW-1:0]        count,
    input  logic [IW-1:0]        rd_idx,
    input  logic [CW-1:0]        cur_idx,
    input  logic [ADDR_BITS-1:0] prev_val,
    input  logic                 prev_g,
    output logic [ADDR_BITS-1:0] val,
    output logic                 g,
    output cell_flag_t           flags,
    output logic [ADDR_BITS-1:0] rd_data
);

    logic [ADDR_BITS-1:0] val_reg;
    logic                 gt_reg;
    logic                 is_valid;
    logic                 at_end;
    logic                 gt_now;

    assign is_valid = (CW'(IDX) < count);
    assign at_end   = (CW'(IDX) == count);
    assign gt_now   = is_valid && (val_reg > addr);

    assign flags.eq     = is_valid && (val_reg == addr);
    assign flags.gt_cur = gt_now && (cur_idx == CW'(IDX));
    assign rd_data      = (rd_idx == IW'(IDX)) ? val_reg : '0;

    // first free slot counts as "above" so an append lands there
    assign g   = gt_reg || at_end;
    assign val = val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= 1'b0;
        end
        else if (ctrl.capture)
        begin
            gt_reg <= gt_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert && g)
        begin
            val_reg <= prev_g ? prev_val : addr;
        end
    end

endmodule

>>> verif/sorted_breakpoint_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted breakpoint table testbench
// Drives add, clear, rewind and get-next commands through the stream input.
// Each accepted item is scored by a local model of the set and its cursor.
// A short scripted run comes first. Random phases then churn a small address
// pool, fill the table until it is full, and walk the cursor past the end.
// Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module sorted_breakpoint_table_test;
    import sbt_pkg::*;

    localparam int          DEPTH    = 256;
    localparam int          AW       = 24;
    localparam logic [23:0] END_MARK = 24'hFFFFFF;
    localparam int          HOLD_CYC = 200;   // long receiver hold-off

    // one result: address handed back and its status
    typedef struct packed {
        logic [AW-1:0] next_address;
        status_t       status;
    } bp_reply_t;

    // scripted item; 'typed' marks a reply that is written out in the row
    typedef struct packed {
        cmd_t          cmd;
        logic [AW-1:0] addr;
        bit            typed;
        bp_reply_t     reply;
    } script_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [AW-1:0]       s_tdata;   // [23:0] address
    logic [CMD_W-1:0]    s_tuser;   // [1:0] cmd
    logic                m_tvalid;
    logic                m_tready;
    logic [AW-1:0]       m_tdata;   // [23:0] next_address
    logic [STATUS_W-1:0] m_tuser;   // [2:0] status

    // model of the set and its cursor
    logic [AW-1:0] bp_entries [DEPTH];
    int unsigned   bp_count;
    int unsigned   cur_pos;
    bit            cur_live;
    int unsigned   peak_count;

    bp_reply_t     replies_due [$];
    bp_reply_t     reply_seen;
    logic [AW-1:0] addr_pool [48];
    script_row_t   script [25];

    bit            quiet;        // last stretch: neither side idles
    bit            hold_req;     // asks the receiver for one long hold-off
    int            calm_left;    // sender items left without gaps
    int            errors;
    int            items_sent;
    int            replies_checked;
    int            status_seen [6];

    sorted_breakpoint_table #(
        .TABLE_DEPTH (DEPTH),
        .ADDR_BITS   (AW)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one command to the model and return the reply it should give.
    // Only indices below bp_count are ever read.
    function automatic bp_reply_t table_step(input cmd_t c, input logic [AW-1:0] a);
        bp_reply_t   r;
        int unsigned pos;
        r.next_address = '0;
        r.status       = ST_OK;
        case (c)
            CMD_ADD:
            begin
                pos = 0;
                while (pos < bp_count && bp_entries[pos] < a)
                    pos++;
                if (pos < bp_count && bp_entries[pos] == a)
                    r.status = ST_DUP;
                else if (bp_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = bp_count; i > pos; i--)
                        bp_entries[i] = bp_entries[i-1];
                    bp_entries[pos] = a;
                    // cursor follows its entry; past the end it stays past the end
                    if (cur_live)
                    begin
                        if (cur_pos >= bp_count)
                            cur_pos = bp_count + 1;
                        else if (cur_pos >= pos)
                            cur_pos++;
                    end
                    bp_count++;
                    if (bp_count > peak_count)
                        peak_count = bp_count;
                end
            end
            CMD_CLEAR:
                bp_count = 0;   // cursor is left where it was
            CMD_REWIND:
            begin
                cur_live = 1'b0;
                cur_pos  = 0;
            end
            default:
            begin
                if (bp_count == 0)
                    r.status = ST_EMPTY;
                else if (!cur_live)
                begin
                    cur_live       = 1'b1;
                    cur_pos        = 0;
                    r.next_address = bp_entries[0];
                end
                else if (cur_pos >= bp_count)
                    r.status = ST_PAST;
                else
                begin
                    cur_pos++;
                    if (cur_pos < bp_count)
                        r.next_address = bp_entries[cur_pos];
                    else
                    begin
                        r.next_address = END_MARK;
                        r.status       = ST_END;
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Offer one item, possibly after a gap, and log its reply once accepted.
    // s_tvalid stays high after the handshake unless the next call idles.
    task automatic send_item(input cmd_t c, input logic [AW-1:0] a,
                             input bit typed, input bp_reply_t typed_reply);
        bp_reply_t r;
        if (!quiet)
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 3) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else if ($urandom_range(0, 15) == 0)
                calm_left = $urandom_range(10, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= a;
        do
            @(posedge clk);
        while (!s_tready);
        r = table_step(c, a);
        if (typed)
            r = typed_reply;
        replies_due.push_back(r);
        items_sent++;
    endtask

    // Mixed traffic over a small pool, so duplicates and reordering are common
    task automatic send_mixed(input int n);
        int   w;
        cmd_t c;
        repeat (n)
        begin
            w = $urandom_range(0, 99);
            if (w < 45)
                c = CMD_ADD;
            else if (w < 80)
                c = CMD_NEXT;
            else if (w < 92)
                c = CMD_REWIND;
            else
                c = CMD_CLEAR;
            send_item(c, addr_pool[$urandom_range(0, 47)], 1'b0, '0);
        end
    endtask

    // Sender stops and waits for every outstanding reply
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall bursts, one long hold-off on request, and a
    // steady ready in the last stretch.
    initial
    begin
        int n;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYC) @(posedge clk);
            end
            else
            begin
                n = $urandom_range(1, 14);
                case ($urandom_range(0, 7))
                    0, 1, 2: m_tready <= 1'b0;
                    3:
                    begin
                        m_tready <= 1'b1;
                        n = 40;   // stretch with no stalls
                    end
                    default: m_tready <= 1'b1;
                endcase
                repeat (n) @(posedge clk);
            end
        end
    end

    // Score every reply against the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply with none due, got next_address %h status %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                reply_seen = replies_due.pop_front();
                replies_checked++;
                if (m_tuser < 6)
                    status_seen[m_tuser]++;
                if (m_tdata !== reply_seen.next_address)
                begin
                    $display("%0t: next_address mismatch, expected %h, got %h",
                             $time, reply_seen.next_address, m_tdata);
                    errors++;
                end
                if (m_tuser !== reply_seen.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, reply_seen.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("%0t: timed out with %0d replies still due", $time, replies_due.size());
        $display("sorted_breakpoint_table regression: fail");
        $finish;
    end

    initial
    begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= CMD_ADD;
        rst_n    <= 1'b0;
        quiet     = 1'b0;
        hold_req  = 1'b0;
        calm_left = 0;
        errors    = 0;
        items_sent      = 0;
        replies_checked = 0;
        bp_count   = 0;
        cur_pos    = 0;
        cur_live   = 1'b0;
        peak_count = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // pool of full-width addresses, with both extremes in it
        foreach (addr_pool[i])
            addr_pool[i] = AW'($urandom);
        addr_pool[0] = 24'h000000;
        addr_pool[1] = END_MARK;

        // Scripted run: empty set, extremes, duplicate, insert under the cursor,
        // walk to the sentinel and past it, add while past the end, clear with
        // the cursor left beyond the new size.
        script = '{
            '{CMD_NEXT,   24'h000000, 1'b1, '{24'h000000, ST_EMPTY}},
            '{CMD_ADD,    24'h000000, 1'b1, '{24'h000000, ST_OK}},
            '{CMD_ADD,    24'hFFFFFF, 1'b1, '{24'h000000, ST_OK}},
            '{CMD_ADD,    24'h000000, 1'b1, '{24'h000000, ST_DUP}},
            '{CMD_ADD,    24'h800000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_ADD,    24'h7FFFFF, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_ADD,    24'h400000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_ADD,    24'h000001, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b1, '{24'hFFFFFF, ST_END}},
            '{CMD_NEXT,   24'h000000, 1'b1, '{24'h000000, ST_PAST}},
            '{CMD_ADD,    24'h555555, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_REWIND, 24'h000000, 1'b1, '{24'h000000, ST_OK}},
            '{CMD_CLEAR,  24'h000000, 1'b1, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b1, '{24'h000000, ST_EMPTY}},
            '{CMD_ADD,    24'hAAAAAA, 1'b1, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_CLEAR,  24'h000000, 1'b1, '{24'h000000, ST_OK}},
            '{CMD_ADD,    24'h123456, 1'b0, '{24'h000000, ST_OK}},
            '{CMD_NEXT,   24'h000000, 1'b0, '{24'h000000, ST_OK}}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_item(script[i].cmd, script[i].addr, script[i].typed, script[i].reply);

        // churn over the pool; receiver holds off at the start so the block
        // backs up and stalls its input
        hold_req = 1'b1;
        send_mixed(350);
        drain_replies();

        // fill from empty with full-width addresses until the table is full
        send_item(CMD_CLEAR, AW'($urandom), 1'b0, '0);
        send_item(CMD_REWIND, AW'($urandom), 1'b0, '0);
        while (bp_count < DEPTH)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(CMD_NEXT, AW'($urandom), 1'b0, '0);
            else
                send_item(CMD_ADD, AW'($urandom), 1'b0, '0);
        end
        // full table: fresh addresses are refused, known ones are duplicates
        repeat (2)
            send_item(CMD_ADD, AW'($urandom), 1'b0, '0);
        repeat (2)
            send_item(CMD_ADD, bp_entries[$urandom_range(0, DEPTH - 1)], 1'b0, '0);

        // walk the whole full set, through the sentinel and past the end
        send_item(CMD_REWIND, 24'h000000, 1'b0, '0);
        repeat (DEPTH + 3)
            send_item(CMD_NEXT, AW'($urandom), 1'b0, '0);
        send_item(CMD_CLEAR, 24'h000000, 1'b0, '0);
        send_item(CMD_NEXT, 24'h000000, 1'b0, '0);
        repeat (4)
            send_item(CMD_ADD, addr_pool[$urandom_range(0, 47)], 1'b0, '0);
        send_item(CMD_NEXT, 24'h000000, 1'b0, '0);

        // last stretch at full rate on both sides
        quiet = 1'b1;
        send_mixed(200);

        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d items sent, %0d replies checked, %0d mismatches, largest set %0d",
                 items_sent, replies_checked, errors, peak_count);
        $display("statuses seen: ok %0d dup %0d full %0d empty %0d end %0d past %0d",
                 status_seen[ST_OK], status_seen[ST_DUP], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_END], status_seen[ST_PAST]);
        if (errors == 0)
            $display("sorted_breakpoint_table regression: pass");
        else
            $display("sorted_breakpoint_table regression: fail");
        $finish;
    end

endmodule
